// File: hdl/ckel_pkg.sv
// Shared widths, register codes, constant tables and the sideband type
// for the covariance kernel element. No dependencies.
`default_nettype none

package ckel_pkg;

    localparam int FRAC_BITS = 16;

    localparam int POS_W  = 32;
    localparam int WORD_W = 32;
    localparam int COV_W  = 64;
    localparam int CUT_W  = 17;
    localparam int CUT_FB = 16;
    localparam int MODE_W = 2;
    localparam int IDX_W  = 2;

    // distance and length sum
    localparam int DIST_W = POS_W + 1;
    // quotient r = 2d/L in Q.F, below 32 (larger values are flagged, not saturated)
    localparam int Q_W    = FRAC_BITS + 5;
    localparam int DVS_W  = DIST_W + 3;
    localparam int REM_W  = DIST_W + 4;

    // correlation: unsigned Q1.F and signed form
    localparam int C_W    = FRAC_BITS + 1;
    localparam int CS_W   = FRAC_BITS + 2;
    localparam int CMP_W  = CS_W + CUT_W + CUT_FB;
    localparam int X_W    = FRAC_BITS + 6;
    localparam int SQ_W   = 2 * (FRAC_BITS + 3);
    localparam int LIN_W  = 33 + FRAC_BITS;

    // exp(-x) datapath in Q.30
    localparam int EXP_FB   = 30;
    localparam int T_W      = 31;
    localparam int V_W      = 29;
    localparam int RCP_W    = 35;
    localparam int RCP_SH   = 34;
    localparam int HORNER_N = 12;
    localparam int SQUARE_N = 6;
    localparam int EXP_LAST = 2 * HORNER_N + SQUARE_N;
    localparam int MUL_H_W  = V_W + T_W;
    localparam int MUL_R_W  = V_W + RCP_W;
    localparam int MUL_S_W  = 2 * T_W;

    localparam logic [T_W-1:0] T_ONE = {1'b1, {EXP_FB{1'b0}}};
    localparam logic [C_W-1:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};

    // 2(1 - e^-1) in Q.32
    localparam logic [32:0] LIN_K = 33'd5429874255;

    // ceil(2^34 / k): exact floor(p / k) for p below 2^29
    localparam logic [RCP_W-1:0] RECIP [1:HORNER_N] = '{
        35'd17179869184, 35'd8589934592, 35'd5726623062, 35'd4294967296,
        35'd3435973837,  35'd2863311531, 35'd2454267027, 35'd2147483648,
        35'd1908874354,  35'd1717986919, 35'd1561806290, 35'd1431655766
    };

    localparam logic [MODE_W-1:0] MODE_DIAG  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LIN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_GAUSS = 2'd3;

    localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_CUTOFF = 2'd1;

    typedef struct packed {
        logic [COV_W-1:0]       prod;
        logic                   diag;
        logic                   len_zero;
        logic                   dist_zero;
        logic signed [CS_W-1:0] c_lin;
    } side_t;

endpackage

`default_nettype wire

// File: hdl/ckel_if.sv
// Channel interfaces: input word, result word and register write port.
// Depends on ckel_pkg.
`default_nettype none

interface ckel_item_if;
    import ckel_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_a;
    logic signed [POS_W-1:0] pos_b;
    logic [WORD_W-1:0]       sdev_a;
    logic [WORD_W-1:0]       sdev_b;
    logic [WORD_W-1:0]       clen_a;
    logic [WORD_W-1:0]       clen_b;
    logic                    on_diagonal;
    modport source (output valid, pos_a, pos_b, sdev_a, sdev_b, clen_a, clen_b,
                    on_diagonal, input ready);
    modport sink (input valid, pos_a, pos_b, sdev_a, sdev_b, clen_a, clen_b,
                  on_diagonal, output ready);
endinterface

interface ckel_result_if;
    import ckel_pkg::*;
    logic             valid;
    logic             ready;
    logic [COV_W-1:0] covariance;
    logic             was_cut;
    modport source (output valid, covariance, was_cut, input ready);
    modport sink (input valid, covariance, was_cut, output ready);
endinterface

interface ckel_cfg_if;
    import ckel_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CUT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/ckel_div.sv
// Pipelined restoring divider: r = floor(2d * 2^F / L), one quotient bit
// per stage, with a flag for r >= 32. Depends on ckel_pkg.
`default_nettype none

module ckel_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [ckel_pkg::DIST_W-1:0] dist_in,
    input  wire logic [ckel_pkg::DIST_W-1:0] len,
    input  wire ckel_pkg::side_t            side_in,
    output logic                            out_valid,
    output logic [ckel_pkg::Q_W-1:0]        quot,
    output logic                            over,
    output ckel_pkg::side_t                 side_out
);
    import ckel_pkg::*;

    logic [Q_W:0]       valid_reg;
    logic [Q_W:0]       over_reg;
    logic [REM_W-1:0]   rem_reg [0:Q_W];
    logic [DVS_W-1:0]   dvs_reg [0:Q_W];
    logic [Q_W-1:0]     quot_reg [0:Q_W];
    side_t              side_reg [0:Q_W];
    logic [REM_W-1:0]   rem_next [1:Q_W];
    logic [Q_W:1]       bit_next;

    // divisor is L*8; the first four bits are the integer part of d/L
    always_comb
    begin
        for (int i = 1; i <= Q_W; i++)
        begin
            bit_next[i] = rem_reg[i-1] >= {1'b0, dvs_reg[i-1]};
            rem_next[i] = (bit_next[i] ? rem_reg[i-1] - {1'b0, dvs_reg[i-1]}
                                       : rem_reg[i-1]) << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[Q_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {4'b0, dist_in};
            dvs_reg[0]  <= {len, 3'b0};
            over_reg[0] <= {4'b0, dist_in} >= {len, 4'b0};
            quot_reg[0] <= '0;
            side_reg[0] <= side_in;
            for (int i = 1; i <= Q_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                dvs_reg[i]  <= dvs_reg[i-1];
                over_reg[i] <= over_reg[i-1];
                quot_reg[i] <= {quot_reg[i-1][Q_W-2:0], bit_next[i]};
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign quot      = quot_reg[Q_W];
    assign over      = over_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

`default_nettype wire

// File: hdl/ckel_exp.sv
// Pipelined exp(-x) in Q.30: twelve Horner stages (multiply, then divide
// by k via reciprocal) and six squaring stages. Depends on ckel_pkg.
`default_nettype none

module ckel_exp (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [ckel_pkg::X_W-1:0] x,
    input  wire ckel_pkg::side_t         side_in,
    output logic                         out_valid,
    output logic [ckel_pkg::C_W-1:0]     y,
    output ckel_pkg::side_t              side_out
);
    import ckel_pkg::*;

    logic [EXP_LAST:0]   valid_reg;
    logic [EXP_LAST:0]   zero_reg;
    side_t               side_reg [0:EXP_LAST];
    logic [T_W-1:0]      w_reg [0:EXP_LAST];
    logic [V_W-1:0]      v_reg [0:2*HORNER_N-2];
    logic [MUL_H_W-1:0]  hmul [0:HORNER_N-1];
    logic [MUL_R_W-1:0]  rmul [0:HORNER_N-1];
    logic [MUL_S_W-1:0]  sq [0:SQUARE_N-1];

    // even stage holds t, odd stage holds floor(v*t / 2^30)
    always_comb
    begin
        for (int j = 0; j < HORNER_N; j++)
        begin
            hmul[j] = MUL_H_W'(v_reg[2*j]) * MUL_H_W'(w_reg[2*j]);
            rmul[j] = MUL_R_W'(w_reg[2*j+1][V_W-1:0]) * MUL_R_W'(RECIP[HORNER_N-j]);
        end
        for (int s = 0; s < SQUARE_N; s++)
        begin
            sq[s] = MUL_S_W'(w_reg[2*HORNER_N+s]) * MUL_S_W'(w_reg[2*HORNER_N+s]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[EXP_LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // x >= 32 gives zero; otherwise v = x/64 in Q.30
            zero_reg[0] <= x[FRAC_BITS+5];
            v_reg[0]    <= V_W'(x[FRAC_BITS+4:0]) << (24 - FRAC_BITS);
            w_reg[0]    <= T_ONE;
            side_reg[0] <= side_in;
            for (int i = 1; i <= EXP_LAST; i++)
            begin
                zero_reg[i] <= zero_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 1; i <= 2*HORNER_N-2; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            for (int j = 0; j < HORNER_N; j++)
            begin
                w_reg[2*j+1] <= T_W'(hmul[j][MUL_H_W-1:EXP_FB]);
                w_reg[2*j+2] <= T_ONE - T_W'(rmul[j][MUL_R_W-1:RCP_SH]);
            end
            for (int s = 0; s < SQUARE_N; s++)
            begin
                w_reg[2*HORNER_N+s+1] <= sq[s][T_W-1+EXP_FB:EXP_FB];
            end
        end
    end

    assign out_valid = valid_reg[EXP_LAST];
    assign y         = zero_reg[EXP_LAST] ? '0
                                          : w_reg[EXP_LAST][T_W-1:EXP_FB-FRAC_BITS];
    assign side_out  = side_reg[EXP_LAST];

endmodule

`default_nettype wire

// File: hdl/covariance_kernel_element.sv
// Covariance kernel element, top level: front end, divider, correlation
// shaping, exp pipeline, cutoff test and scaling. Depends on ckel_pkg,
// ckel_if, ckel_div, ckel_exp.
//
//   port     dir     role        payload
//   item     sink    input word  pos_a, pos_b, sdev_a/b, clen_a/b, on_diagonal
//   result   source  output word covariance, was_cut
//   cfg      sink    reg write   index, data (always ready)
//
// One word per cycle while result is not stalled; the depth is set by the
// one-bit-per-stage divider and the 31-stage exp pipeline.
// Reset clears valid bits and registers (mode diagonal, cutoff zero).
// A stall on result freezes every stage; the output register takes a new
// word whenever it is empty or being read.
`default_nettype none

module covariance_kernel_element (
    input wire logic      clk,
    input wire logic      rst_n,
    ckel_item_if.sink     item,
    ckel_result_if.source result,
    ckel_cfg_if.sink      cfg
);
    import ckel_pkg::*;

    logic                    en;
    logic [MODE_W-1:0]       mode_reg;
    logic signed [CUT_W-1:0] cut_reg;

    // front stage
    logic signed [POS_W:0]   pdiff;
    logic [DIST_W-1:0]       dist_next;
    logic                    s1_valid_reg;
    logic [DIST_W-1:0]       s1_dist_reg;
    logic [DIST_W-1:0]       s1_len_reg;
    side_t                   s1_side_reg;
    side_t                   s1_side_next;

    // divider
    logic                    d_valid;
    logic [Q_W-1:0]          d_quot;
    logic                    d_over;
    side_t                   d_side;

    // shaping
    logic                    p1_valid_reg;
    logic [Q_W-1:0]          p1_quot_reg;
    logic                    p1_over_reg;
    logic                    p1_far_reg;
    logic                    p1_linover_reg;
    logic [SQ_W-1:0]         p1_sq_reg;
    logic [LIN_W-1:0]        p1_lin_reg;
    side_t                   p1_side_reg;
    logic                    p2_valid_reg;
    logic [X_W-1:0]          p2_x_reg;
    logic [X_W-1:0]          x_next;
    side_t                   p2_side_reg;
    side_t                   p2_side_next;

    // exp
    logic                    e_valid;
    logic [C_W-1:0]          e_y;
    side_t                   e_side;

    // cutoff and scaling
    logic signed [CS_W-1:0]  c_sel;
    logic                    keep;
    logic                    c_valid_reg;
    logic [C_W-1:0]          c_reg;
    logic                    c_cut_reg;
    logic [COV_W-1:0]        c_prod_reg;
    logic                    l_valid_reg;
    logic [WORD_W+C_W-1:0]   l_lo_reg;
    logic [WORD_W-1:0]       l_hi_reg;
    logic [C_W-1:0]          l_c_reg;
    logic                    l_cut_reg;
    logic                    h_valid_reg;
    logic [WORD_W+C_W-1:0]   h_lo_reg;
    logic [WORD_W+C_W-1:0]   h_hi_reg;
    logic                    h_cut_reg;
    logic                    out_valid_reg;
    logic [COV_W-1:0]        out_cov_reg;
    logic                    out_cut_reg;

    assign en          = !out_valid_reg || result.ready;
    assign item.ready  = en;
    assign cfg.ready   = 1'b1;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DIAG;
            cut_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MODE:   mode_reg <= cfg.data[MODE_W-1:0];
                REG_CUTOFF: cut_reg  <= $signed(cfg.data);
                default:    ;
            endcase
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            c_valid_reg   <= 1'b0;
            l_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= item.valid;
            p1_valid_reg  <= d_valid;
            p2_valid_reg  <= p1_valid_reg;
            c_valid_reg   <= e_valid;
            l_valid_reg   <= c_valid_reg;
            h_valid_reg   <= l_valid_reg;
            out_valid_reg <= h_valid_reg;
        end
    end

    // ---------------- front: |pa - pb|, length sum, sdev product ----------------
    always_comb
    begin
        pdiff     = {item.pos_a[POS_W-1], item.pos_a} - {item.pos_b[POS_W-1], item.pos_b};
        dist_next = DIST_W'(pdiff[POS_W] ? -pdiff : pdiff);
        s1_side_next.prod      = COV_W'(item.sdev_a) * COV_W'(item.sdev_b);
        s1_side_next.diag      = item.on_diagonal;
        s1_side_next.len_zero  = (item.clen_a == '0) && (item.clen_b == '0);
        s1_side_next.dist_zero = item.pos_a == item.pos_b;
        s1_side_next.c_lin     = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dist_reg <= dist_next;
            s1_len_reg  <= {1'b0, item.clen_a} + {1'b0, item.clen_b};
            s1_side_reg <= s1_side_next;
        end
    end

    ckel_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .dist_in   (s1_dist_reg),
        .len       (s1_len_reg),
        .side_in   (s1_side_reg),
        .out_valid (d_valid),
        .quot      (d_quot),
        .over      (d_over),
        .side_out  (d_side)
    );

    // ---------------- shaping: r^2 and linear product ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_quot_reg    <= d_quot;
            p1_over_reg    <= d_over;
            p1_far_reg     <= d_quot >= (Q_W'(6) << FRAC_BITS);
            p1_linover_reg <= d_quot >= (Q_W'(1) << (FRAC_BITS + 1));
            p1_sq_reg      <= SQ_W'(d_quot[FRAC_BITS+2:0]) * SQ_W'(d_quot[FRAC_BITS+2:0]);
            // s = r/2 in Q.F
            p1_lin_reg     <= LIN_W'(LIN_K) * LIN_W'(d_quot[FRAC_BITS:1]);
            p1_side_reg    <= d_side;
        end
    end

    always_comb
    begin
        p2_side_next = p1_side_reg;
        if (p1_linover_reg || p1_over_reg)
        begin
            p2_side_next.c_lin = -$signed(CS_W'(1));
        end
        else
        begin
            p2_side_next.c_lin = $signed({1'b0, ONE_F})
                               - $signed({1'b0, p1_lin_reg[LIN_W-1:32]});
        end
        if (mode_reg == MODE_GAUSS)
        begin
            x_next = p1_sq_reg[SQ_W-1:FRAC_BITS];
        end
        else
        begin
            x_next = X_W'(p1_quot_reg);
        end
        // far away: force x to 32 so exp gives zero
        if (p1_over_reg || (mode_reg == MODE_GAUSS && p1_far_reg))
        begin
            x_next = X_W'(1) << (FRAC_BITS + 5);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_x_reg    <= x_next;
            p2_side_reg <= p2_side_next;
        end
    end

    ckel_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .x         (p2_x_reg),
        .side_in   (p2_side_reg),
        .out_valid (e_valid),
        .y         (e_y),
        .side_out  (e_side)
    );

    // ---------------- correlation select and cutoff ----------------
    always_comb
    begin
        c_sel = $signed({1'b0, e_y});
        if (e_side.len_zero)
        begin
            c_sel = e_side.dist_zero ? $signed({1'b0, ONE_F}) : '0;
        end
        else if (mode_reg == MODE_LIN)
        begin
            c_sel = e_side.c_lin;
        end
        keep = (CMP_W'(c_sel) <<< CUT_FB) > (CMP_W'(cut_reg) <<< FRAC_BITS);
        if (mode_reg == MODE_LIN && (c_sel[CS_W-1] || c_sel == '0))
        begin
            keep = 1'b0;
        end
        // diagonal mode ignores the cutoff
        if (mode_reg == MODE_DIAG)
        begin
            c_sel = e_side.diag ? $signed({1'b0, ONE_F}) : '0;
            keep  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg      <= keep ? c_sel[C_W-1:0] : '0;
            c_cut_reg  <= !keep;
            c_prod_reg <= e_side.prod;

            l_lo_reg   <= (WORD_W+C_W)'(c_prod_reg[WORD_W-1:0]) * (WORD_W+C_W)'(c_reg);
            l_hi_reg   <= c_prod_reg[COV_W-1:WORD_W];
            l_c_reg    <= c_reg;
            l_cut_reg  <= c_cut_reg;

            h_hi_reg   <= (WORD_W+C_W)'(l_hi_reg) * (WORD_W+C_W)'(l_c_reg);
            h_lo_reg   <= l_lo_reg;
            h_cut_reg  <= l_cut_reg;

            out_cov_reg <= (COV_W'(h_hi_reg) << (WORD_W - FRAC_BITS))
                         + COV_W'(h_lo_reg >> FRAC_BITS);
            out_cut_reg <= h_cut_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.covariance = out_cov_reg;
    assign result.was_cut    = out_cut_reg;

    // ---------------- checks ----------------
    a_diag_not_cut: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && mode_reg == MODE_DIAG |-> !result.was_cut)
        else $error("diagonal mode word marked as cut");

    a_cut_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.was_cut |-> result.covariance == '0)
        else $error("cut word carries nonzero covariance");

    a_corr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> c_reg <= ONE_F)
        else $error("correlation above one");

endmodule

`default_nettype wire

// File: dv/covariance_kernel_element_tb.sv
// Self-checking bench for the covariance kernel element: directed table, then
// random words, checked against a behavioral covariance predictor.
// Depends on ckel_pkg, ckel_if and the covariance_kernel_element RTL.
`timescale 1ns / 100ps

module covariance_kernel_element_tb;
    import ckel_pkg::*;

    localparam int LATENCY   = FRAC_BITS + 44;
    localparam int CYCLE_CAP = 2000000;
    localparam int N_RANDOM  = 1600;

    // index with no register behind it
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [31:0] pos_a;
        logic signed [31:0] pos_b;
        logic [31:0]        sdev_a;
        logic [31:0]        sdev_b;
        logic [31:0]        clen_a;
        logic [31:0]        clen_b;
        logic               on_diagonal;
    } elem_t;

    typedef struct packed {
        logic [63:0] covariance;
        logic        was_cut;
    } cov_t;

    // directed row: one word, and a typed-in result where it is obvious
    typedef struct {
        elem_t e;
        bit    fixed;
        cov_t  r;
    } drow_t;

    logic clk;
    logic rst_n;
    ckel_item_if   item ();
    ckel_result_if result ();
    ckel_cfg_if    cfg ();

    covariance_kernel_element u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    logic [MODE_W-1:0]       mode_q;
    logic signed [CUT_W-1:0] cutoff_q;
    cov_t                    cov_expected[$];
    int                      errors;
    int                      cycles;
    int                      send_idle_pct;
    int                      recv_stall_pct;
    int                      n_results;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("timeout at %0t", $time);
            $display("covariance_kernel_element_tb: done, errors");
            $finish;
        end
    end

    // exp(-x), x and result in Q.F
    function automatic logic [63:0] exp_neg_q(logic [63:0] x);
        logic [63:0] v;
        logic [63:0] t;
        if (x >= (64'd32 << FRAC_BITS))
            return 64'd0;
        v = x << (24 - FRAC_BITS);
        t = 64'd1 << 30;
        for (int k = 12; k >= 1; k--)
            t = (64'd1 << 30) - ((v * t) >> 30) / 64'(k);
        for (int k = 0; k < 6; k++)
            t = (t * t) >> 30;
        return t >> (30 - FRAC_BITS);
    endfunction

    function automatic cov_t predict_cov(elem_t e);
        cov_t             o;
        logic [63:0]      prod;
        logic [63:0]      d;
        logic [63:0]      len;
        logic [63:0]      s;
        logic [63:0]      r;
        logic [127:0]     scaled;
        longint signed    c;
        longint signed    pa;
        longint signed    pb;
        bit               keep;
        prod = 64'(e.sdev_a) * 64'(e.sdev_b);
        pa = longint'(e.pos_a);
        pb = longint'(e.pos_b);
        d = (pa >= pb) ? 64'(pa - pb) : 64'(pb - pa);
        len = 64'(e.clen_a) + 64'(e.clen_b);
        if (mode_q == MODE_DIAG)
        begin
            o.covariance = e.on_diagonal ? prod : 64'd0;
            o.was_cut = 1'b0;
            return o;
        end
        if (len == 0)
            c = (d == 0) ? (longint'(1) <<< FRAC_BITS) : longint'(0);
        else if (mode_q == MODE_LIN)
        begin
            s = (d << FRAC_BITS) / len;
            if (s >= (64'd1 << FRAC_BITS))
                c = -longint'(1);
            else
                c = (longint'(1) <<< FRAC_BITS) - longint'((128'(LIN_K) * s) >> 32);
        end
        else
        begin
            r = (d << (FRAC_BITS + 1)) / len;
            if (mode_q == MODE_EXP)
                c = exp_neg_q(r);
            else if (r >= (64'd6 << FRAC_BITS))
                c = longint'(0);
            else
                c = exp_neg_q((r * r) >> FRAC_BITS);
        end
        keep = (c * (longint'(1) <<< 16)) > (longint'(cutoff_q) * (longint'(1) <<< FRAC_BITS));
        if (mode_q == MODE_LIN && c <= 0)
            keep = 1'b0;
        if (keep)
        begin
            scaled = (128'(prod) * 128'(c)) >> FRAC_BITS;
            o.covariance = scaled[63:0];
            o.was_cut = 1'b0;
        end
        else
        begin
            o.covariance = 64'd0;
            o.was_cut = 1'b1;
        end
        return o;
    endfunction

    // result side: random stall and compare with oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                n_results <= n_results + 1;
                if (cov_expected.size() == 0)
                begin
                    $display("%0t: unexpected word cov=%h cut=%b", $time,
                             result.covariance, result.was_cut);
                    errors <= errors + 1;
                end
                else
                begin
                    if (result.covariance !== cov_expected[0].covariance)
                    begin
                        $display("%0t: covariance expected %h actual %h", $time,
                                 cov_expected[0].covariance, result.covariance);
                    end
                    if (result.was_cut !== cov_expected[0].was_cut)
                    begin
                        $display("%0t: was_cut expected %b actual %b", $time,
                                 cov_expected[0].was_cut, result.was_cut);
                    end
                    if (result.covariance !== cov_expected[0].covariance
                        || result.was_cut !== cov_expected[0].was_cut)
                    begin
                        errors <= errors + 1;
                    end
                    void'(cov_expected.pop_front());
                end
            end
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CUT_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_MODE)
            mode_q = val[MODE_W-1:0];
        else if (idx == REG_CUTOFF)
            cutoff_q = val;
    endtask

    task automatic drain_results();
        while (cov_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic send_elem(elem_t e, bit fixed, cov_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid       <= 1'b1;
        item.pos_a       <= e.pos_a;
        item.pos_b       <= e.pos_b;
        item.sdev_a      <= e.sdev_a;
        item.sdev_b      <= e.sdev_b;
        item.clen_a      <= e.clen_a;
        item.clen_b      <= e.clen_b;
        item.on_diagonal <= e.on_diagonal;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        cov_expected.push_back(fixed ? r : predict_cov(e));
    endtask

    task automatic end_burst();
        item.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(32'h0003_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic elem_t rand_elem();
        elem_t e;
        e.sdev_a = rand_word();
        e.sdev_b = rand_word();
        e.on_diagonal = 1'($urandom_range(1));
        e.pos_a = $urandom;
        if ($urandom_range(3) == 0)
        begin
            e.pos_b = $urandom;
            e.clen_a = rand_word();
            e.clen_b = rand_word();
        end
        else
        begin
            // near pairs so correlations land in the interesting range
            e.pos_b = e.pos_a + $signed(32'($urandom_range(32'h0008_0000)) - 32'h0004_0000);
            e.clen_a = $urandom_range(32'h0004_0000);
            e.clen_b = ($urandom_range(15) == 0) ? 32'd0 : $urandom_range(32'h0004_0000);
            if ($urandom_range(15) == 0)
                e.pos_b = e.pos_a;
        end
        return e;
    endfunction

    function automatic elem_t mk(logic [31:0] pa, logic [31:0] pb, logic [31:0] sa,
                                 logic [31:0] sb, logic [31:0] ca, logic [31:0] cb,
                                 logic dg);
        elem_t e;
        e.pos_a = pa;
        e.pos_b = pb;
        e.sdev_a = sa;
        e.sdev_b = sb;
        e.clen_a = ca;
        e.clen_b = cb;
        e.on_diagonal = dg;
        return e;
    endfunction

    initial
    begin
        drow_t dtab[$];
        drow_t row;
        int    ph;

        rst_n = 1'b0;
        errors = 0;
        cycles = 0;
        n_results = 0;
        mode_q = MODE_DIAG;
        cutoff_q = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        item.valid = 1'b0;
        item.pos_a = '0;
        item.pos_b = '0;
        item.sdev_a = '0;
        item.sdev_b = '0;
        item.clen_a = '0;
        item.clen_b = '0;
        item.on_diagonal = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // diagonal mode after reset: products read straight off
        row = '{mk(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1), 1'b1,
                '{64'hFFFF_FFFE_0000_0001, 1'b0}};
        dtab.push_back(row);
        row = '{mk(32'd5, 32'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1, 1'b0), 1'b1,
                '{64'd0, 1'b0}};
        dtab.push_back(row);
        row = '{mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0002_0000,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b1,
                '{64'h0000_0002_0000_0000, 1'b0}};
        dtab.push_back(row);
        foreach (dtab[i])
            send_elem(dtab[i].e, dtab[i].fixed, dtab[i].r);
        end_burst();
        drain_results();

        // each correlation mode with extremes and the zero length sum
        for (int m = 1; m <= 3; m++)
        begin
            write_reg(REG_MODE, CUT_W'(m));
            write_reg(REG_CUTOFF, (m == 3) ? 17'h10000 : 17'd0);
            dtab.delete();
            row = '{mk(32'd7, 32'd7, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0, 1'b0), 1'b1,
                    '{64'h0000_0001_0000_0000, 1'b0}};
            dtab.push_back(row);
            row = '{mk(32'd7, 32'd8, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0, 1'b1), 1'b0,
                    '{64'd0, 1'b0}};
            dtab.push_back(row);
            row = '{mk(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'd1, 32'd0, 1'b1), 1'b0, '{64'd0, 1'b0}};
            dtab.push_back(row);
            row = '{mk(32'd0, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0), 1'b0, '{64'd0, 1'b0}};
            dtab.push_back(row);
            row = '{mk(32'd0, 32'h0000_8000, 32'h0002_0000, 32'h0003_0000,
                     32'h0001_0000, 32'h0001_0000, 1'b0), 1'b0, '{64'd0, 1'b0}};
            dtab.push_back(row);
            row = '{mk(32'd0, 32'h0004_0000, 32'h0002_0000, 32'h0003_0000,
                     32'h0000_4000, 32'h0000_4000, 1'b1), 1'b0, '{64'd0, 1'b0}};
            dtab.push_back(row);
            foreach (dtab[i])
                send_elem(dtab[i].e, dtab[i].fixed, dtab[i].r);
            end_burst();
            drain_results();
        end

        // random phases over modes, cutoffs and idling mixes
        for (ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            write_reg(REG_MODE, CUT_W'(ph % 4));
            case (ph / 4)
                0: write_reg(REG_CUTOFF, 17'h10000);
                1: write_reg(REG_CUTOFF, 17'h0FFFF);
                2: write_reg(REG_CUTOFF, 17'd0);
                default: write_reg(REG_CUTOFF, 17'($urandom));
            endcase
            // stray index, ignored by the block
            write_reg(REG_SPARE, 17'($urandom));
            for (int i = 0; i < N_RANDOM / 16; i++)
            begin
                send_elem(rand_elem(), 1'b0, '{64'd0, 1'b0});
                if (ph == 5 && i == 40)
                begin
                    // hold off until the pipe is empty, then resume
                    end_burst();
                    while (cov_expected.size() != 0)
                        @(posedge clk);
                end
            end
            end_burst();
            drain_results();
        end

        if (errors == 0)
            $display("covariance_kernel_element_tb: done, clean");
        else
            $display("covariance_kernel_element_tb: done, errors");
        $finish;
    end
endmodule

// File: files.f
hdl/ckel_pkg.sv
hdl/ckel_if.sv
hdl/ckel_div.sv
hdl/ckel_exp.sv
hdl/covariance_kernel_element.sv
dv/covariance_kernel_element_tb.sv
